### src/rdsp_pkg.sv
package rdsp_pkg;

  // Widths of the result fields seen at the ports.
  localparam int unsigned OUT_LINE_W = 24;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ERR_W      = 3;

  typedef logic [OUT_LINE_W-1:0] line_t;
  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [ERR_W-1:0]      err_t;

  // Result kinds.
  localparam kind_t KIND_APPEND = 3'd0;
  localparam kind_t KIND_DELETE = 3'd1;
  localparam kind_t KIND_TEXT   = 3'd2;
  localparam kind_t KIND_END    = 3'd3;
  localparam kind_t KIND_ERROR  = 3'd4;

  // Error codes.
  localparam err_t ERR_NONE       = 3'd0;
  localparam err_t ERR_MISSING_AT = 3'd1;
  localparam err_t ERR_CORRUPT    = 3'd2;
  localparam err_t ERR_BACK_INS   = 3'd3;
  localparam err_t ERR_BACK_DEL   = 3'd4;
  localparam err_t ERR_EARLY_END  = 3'd5;

  // Characters.
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // One input beat.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_text;
    logic       whole_text_mode;
    logic       final_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    line_t      line_start;
    line_t      line_count;
    logic [7:0] out_byte;
    logic       line_end;
    err_t       error_code;
  } result_t;

endpackage

### src/rdsp_in_reg.sv
module rdsp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rdsp_pkg::item_t    item_i,
  input  logic               advance_i,
  output logic               vld_o,
  output rdsp_pkg::item_t    item_o
);

  logic            vld_q;
  rdsp_pkg::item_t item_q;

  // The held beat leaves whenever the next stage can take it.
  assign in_stall_o = vld_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

### src/rdsp_core.sv
module rdsp_core #(
  parameter int unsigned LINE_WIDTH = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rdsp_pkg::item_t     item_i,
  output logic                res_vld_o,
  output rdsp_pkg::result_t   res_o
);

  localparam int unsigned LW = LINE_WIDTH;
  localparam int unsigned AW = LINE_WIDTH + 4;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_NUM1   = 3'd2;
  localparam logic [2:0] PH_SPACES = 3'd3;
  localparam logic [2:0] PH_NUM2   = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;
  localparam logic [2:0] PH_LSTART = 3'd6;
  localparam logic [2:0] PH_LMID   = 3'd7;

  logic [2:0]    phase_q, phase_d;
  logic          pend_q, pend_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [LW-1:0] num1_q, num1_d;
  logic [LW-1:0] num2_q, num2_d;
  logic          ovf_q, ovf_d;
  logic [LW:0]   afloor_q, afloor_d;
  logic [LW:0]   dfloor_q, dfloor_d;
  logic [LW-1:0] left_q, left_d;
  logic          whole_q, whole_d;

  logic [7:0]    c;
  logic          go, eof, digit;
  logic [AW-1:0] acc1, acc2;
  logic          sat1, sat2;
  logic [LW:0]   sum;
  logic [LW-1:0] left_dec;
  logic          corrupt;

  // Decimal accumulate: v * 10 + digit, saturating at the line bound.
  always_comb begin
    acc1 = (AW'(num1_q) << 3) + (AW'(num1_q) << 1) + AW'(c[3:0]);
    acc2 = (AW'(num2_q) << 3) + (AW'(num2_q) << 1) + AW'(c[3:0]);
    sat1 = |acc1[AW-1:LW];
    sat2 = |acc2[AW-1:LW];
    sum  = {1'b0, num1_q} + {1'b0, num2_q};
    left_dec = (left_q != '0) ? left_q - LW'(1) : left_q;
    corrupt  = (num2_q == '0) || ((cmd_q != rdsp_pkg::CH_A) && (cmd_q != rdsp_pkg::CH_D))
               || ovf_q || sum[LW];
  end

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    cmd_d    = cmd_q;
    num1_d   = num1_q;
    num2_d   = num2_q;
    ovf_d    = ovf_q;
    afloor_d = afloor_q;
    dfloor_d = dfloor_q;
    left_d   = left_q;
    whole_d  = whole_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    c     = item_i.text_byte;
    digit = (c >= rdsp_pkg::CH_ZERO) && (c <= rdsp_pkg::CH_NINE);
    go    = 1'b0;
    eof   = 1'b0;

    if (item_i.first_of_text) begin
      pend_d   = 1'b0;
      cmd_d    = '0;
      num1_d   = '0;
      num2_d   = '0;
      ovf_d    = 1'b0;
      afloor_d = '0;
      dfloor_d = '0;
      left_d   = '0;
      whole_d  = item_i.whole_text_mode;
      phase_d  = PH_IDLE;
      if (c != rdsp_pkg::CH_AT) begin
        res_vld_o        = 1'b1;
        res_o.kind       = rdsp_pkg::KIND_ERROR;
        res_o.error_code = rdsp_pkg::ERR_MISSING_AT;
      end else if (item_i.final_byte) begin
        res_vld_o        = 1'b1;
        res_o.kind       = rdsp_pkg::KIND_ERROR;
        res_o.error_code = rdsp_pkg::ERR_EARLY_END;
      end else begin
        phase_d = item_i.whole_text_mode ? PH_LSTART : PH_CMD;
      end
    end else if (phase_q != PH_IDLE) begin
      // Quote handling: a pending '@' either doubles or closes the text.
      if (pend_q) begin
        pend_d = 1'b0;
        go     = 1'b1;
        eof    = (c != rdsp_pkg::CH_AT);
      end else if (c == rdsp_pkg::CH_AT) begin
        if (item_i.final_byte) begin
          go  = 1'b1;
          eof = 1'b1;
        end else begin
          pend_d = 1'b1;
        end
      end else begin
        go = 1'b1;
      end

      if (go) begin
        unique case (phase_q)
          PH_CMD: begin
            if (eof) begin
              phase_d   = PH_IDLE;
              pend_d    = 1'b0;
              res_vld_o = 1'b1;
              res_o.kind = rdsp_pkg::KIND_END;
            end else begin
              cmd_d   = c;
              num1_d  = '0;
              num2_d  = '0;
              ovf_d   = 1'b0;
              phase_d = PH_NUM1;
            end
          end
          PH_NUM1, PH_SPACES, PH_NUM2, PH_SKIP: begin
            if (eof) begin
              phase_d          = PH_IDLE;
              pend_d           = 1'b0;
              res_vld_o        = 1'b1;
              res_o.kind       = rdsp_pkg::KIND_ERROR;
              res_o.error_code = rdsp_pkg::ERR_EARLY_END;
            end else if (c == rdsp_pkg::CH_NEWLINE) begin
              res_vld_o = 1'b1;
              if (corrupt) begin
                phase_d          = PH_IDLE;
                pend_d           = 1'b0;
                res_o.kind       = rdsp_pkg::KIND_ERROR;
                res_o.error_code = rdsp_pkg::ERR_CORRUPT;
              end else if (cmd_q == rdsp_pkg::CH_A) begin
                if ({1'b0, num1_q} < afloor_q) begin
                  phase_d          = PH_IDLE;
                  pend_d           = 1'b0;
                  res_o.kind       = rdsp_pkg::KIND_ERROR;
                  res_o.error_code = rdsp_pkg::ERR_BACK_INS;
                end else begin
                  afloor_d         = {1'b0, num1_q} + (LW+1)'(1);
                  left_d           = num2_q;
                  phase_d          = PH_LSTART;
                  res_o.kind       = rdsp_pkg::KIND_APPEND;
                  res_o.line_start = rdsp_pkg::line_t'(num1_q);
                  res_o.line_count = rdsp_pkg::line_t'(num2_q);
                end
              end else begin
                if (({1'b0, num1_q} < afloor_q) || ({1'b0, num1_q} < dfloor_q)) begin
                  phase_d          = PH_IDLE;
                  pend_d           = 1'b0;
                  res_o.kind       = rdsp_pkg::KIND_ERROR;
                  res_o.error_code = rdsp_pkg::ERR_BACK_DEL;
                end else begin
                  afloor_d         = {1'b0, num1_q};
                  dfloor_d         = sum;
                  phase_d          = PH_CMD;
                  res_o.kind       = rdsp_pkg::KIND_DELETE;
                  res_o.line_start = rdsp_pkg::line_t'(num1_q);
                  res_o.line_count = rdsp_pkg::line_t'(num2_q);
                end
              end
            end else if (phase_q == PH_NUM1) begin
              if (digit) begin
                num1_d = sat1 ? '1 : acc1[LW-1:0];
                ovf_d  = ovf_q | sat1;
              end else begin
                phase_d = (c == rdsp_pkg::CH_SPACE) ? PH_SPACES : PH_SKIP;
              end
            end else if (phase_q == PH_SPACES) begin
              if (digit) begin
                num2_d  = sat2 ? '1 : acc2[LW-1:0];
                ovf_d   = ovf_q | sat2;
                phase_d = PH_NUM2;
              end else if (c != rdsp_pkg::CH_SPACE) begin
                phase_d = PH_SKIP;
              end
            end else if (phase_q == PH_NUM2) begin
              if (digit) begin
                num2_d = sat2 ? '1 : acc2[LW-1:0];
                ovf_d  = ovf_q | sat2;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_LSTART, PH_LMID: begin
            res_vld_o = 1'b1;
            if (eof) begin
              phase_d = PH_IDLE;
              pend_d  = 1'b0;
              // A last appended line without a newline still closes cleanly.
              if (whole_q || ((phase_q == PH_LMID) && (left_q <= LW'(1)))) begin
                res_o.kind = rdsp_pkg::KIND_END;
              end else begin
                res_o.kind       = rdsp_pkg::KIND_ERROR;
                res_o.error_code = rdsp_pkg::ERR_EARLY_END;
              end
            end else begin
              res_o.kind     = rdsp_pkg::KIND_TEXT;
              res_o.out_byte = c;
              res_o.line_end = (c == rdsp_pkg::CH_NEWLINE);
              if (c == rdsp_pkg::CH_NEWLINE) begin
                if (whole_q) begin
                  phase_d = PH_LSTART;
                end else begin
                  left_d  = left_dec;
                  phase_d = (left_dec == '0) ? PH_CMD : PH_LSTART;
                end
              end else begin
                phase_d = PH_LMID;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // A final byte that leaves the text open replaces any other result.
      if (item_i.final_byte && (phase_d != PH_IDLE)) begin
        phase_d          = PH_IDLE;
        pend_d           = 1'b0;
        res_vld_o        = 1'b1;
        res_o            = '0;
        res_o.kind       = rdsp_pkg::KIND_ERROR;
        res_o.error_code = rdsp_pkg::ERR_EARLY_END;
      end
    end

    if (!fire_i) begin
      res_vld_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pend_q   <= 1'b0;
      cmd_q    <= '0;
      num1_q   <= '0;
      num2_q   <= '0;
      ovf_q    <= 1'b0;
      afloor_q <= '0;
      dfloor_q <= '0;
      left_q   <= '0;
      whole_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      cmd_q    <= cmd_d;
      num1_q   <= num1_d;
      num2_q   <= num2_d;
      ovf_q    <= ovf_d;
      afloor_q <= afloor_d;
      dfloor_q <= dfloor_d;
      left_q   <= left_d;
      whole_q  <= whole_d;
    end
  end

endmodule

### src/rdsp_out_reg.sv
module rdsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_vld_i,
  input  rdsp_pkg::result_t   res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdsp_pkg::result_t   res_o
);

  logic              vld_q;
  rdsp_pkg::result_t res_q;

  assign free_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

### src/rcs_delta_script_parser_top.sv
// Parser for one '@'-quoted revision text, one byte per input beat.
//
// Input channel: in_valid_i / in_stall_o carry a raw byte with first_of_text_i,
// whole_text_mode_i and final_byte_i. A text opens with a beat that has
// first_of_text_i set and the byte '@'. Inside the text '@@' stands for one '@'
// and a lone '@' closes it; the beat after a lone '@' is consumed by the close.
// Output channel: out_valid_o / out_stall_i carry at most one result beat per
// input beat: an append or delete command, an unescaped text byte with a line
// end mark, an end of text, or an error with its code.
//
// Throughput is one beat per cycle while the receiver does not stall. A beat is
// held in the input register, the parser state and checks evaluate it in one
// pass once the output register is free, and the result is registered in the
// output register, from which it is offered.
// When the receiver stalls, the output register holds its beat and the input
// register fills; in_stall_o rises only while both are occupied and the output
// side is stalled. Reset clears the valid flags and parser state; bytes are ignored
// until a beat with first_of_text_i, which also abandons any text in progress.
module rcs_delta_script_parser_top #(
  parameter int unsigned LINE_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_in_i,
  input  logic        first_of_text_i,
  input  logic        whole_text_mode_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [23:0] line_start_o,
  output logic [23:0] line_count_o,
  output logic [7:0]  out_byte_o,
  output logic        line_end_o,
  output logic [2:0]  error_code_o
);

  rdsp_pkg::item_t   item_in;
  rdsp_pkg::item_t   item_held;
  rdsp_pkg::result_t res_next;
  rdsp_pkg::result_t res_out;
  logic              held_vld;
  logic              out_free;
  logic              fire;
  logic              res_vld;

  assign item_in.text_byte       = text_byte_in_i;
  assign item_in.first_of_text   = first_of_text_i;
  assign item_in.whole_text_mode = whole_text_mode_i;
  assign item_in.final_byte      = final_byte_i;

  // The held beat is parsed in the cycle the output register can take its result.
  assign fire = held_vld && out_free;

  rdsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (out_free),
    .vld_o      (held_vld),
    .item_o     (item_held)
  );

  rdsp_core #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_held),
    .res_vld_o (res_vld),
    .res_o     (res_next)
  );

  rdsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o       = res_out.kind;
  assign line_start_o = res_out.line_start;
  assign line_count_o = res_out.line_count;
  assign out_byte_o   = res_out.out_byte;
  assign line_end_o   = res_out.line_end;
  assign error_code_o = res_out.error_code;

endmodule

### src/rdsp_checker.sv
module rdsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [23:0] line_count_o,
  input logic [7:0]  out_byte_o,
  input logic        line_end_o,
  input logic [2:0]  error_code_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // Every emitted command carries a nonzero count and no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == rdsp_pkg::KIND_APPEND || kind_o == rdsp_pkg::KIND_DELETE)
    |-> (line_count_o != 24'd0) && (error_code_o == rdsp_pkg::ERR_NONE))
    else $error("command with zero count or error code");

  // A text byte marks a line end exactly when it is a newline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rdsp_pkg::KIND_TEXT
    |-> (line_end_o == (out_byte_o == rdsp_pkg::CH_NEWLINE)) && (line_count_o == 24'd0))
    else $error("text byte line end mark wrong");

  // Errors carry a real code and nothing else does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == rdsp_pkg::KIND_ERROR) == (error_code_o != rdsp_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  // The input side stalls only while the output side is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without back pressure");

endmodule

bind rcs_delta_script_parser_top rdsp_checker u_rdsp_checker (.*);

### tb/sv/tb_rcs_delta_script_parser_top.sv
// Self-checking bench for the revision text parser.
//
// A behavioral model of the parser runs inside the bench. Every input beat that the
// block accepts is also fed to that model, and any result beat it predicts is queued.
// A checker pops the queue for each result beat that leaves the block and compares it
// field by field. Stimulus is a series of named tests: directed texts first, then a
// long random run made mostly of well-formed delta scripts.
module tb_rcs_delta_script_parser_top;
  import rdsp_pkg::*;

  localparam int unsigned LINE_BITS = 24;
  localparam longint unsigned LINE_MAX = (64'd1 << LINE_BITS) - 64'd1;
  localparam int RANDOM_BEATS = 830;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 20000;

  // Parser phases of the bench model.
  typedef enum logic [2:0] {
    ST_IDLE, ST_CMD, ST_NUM1, ST_SPACES, ST_NUM2, ST_SKIP, ST_LSTART, ST_LMID
  } parse_state_e;

  // Ways the random script generator damages a command.
  typedef enum int {
    FLT_NONE, FLT_OPCODE, FLT_ZERO_COUNT, FLT_BEHIND, FLT_NEAR_MAX, FLT_HUGE, FLT_CUT
  } fault_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_first = 1'b0;
  logic        in_whole = 1'b0;
  logic        in_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  res_kind;
  logic [23:0] res_line_start;
  logic [23:0] res_line_count;
  logic [7:0]  res_byte;
  logic        res_line_end;
  logic [2:0]  res_error;

  rcs_delta_script_parser_top #(
    .LINE_WIDTH(LINE_BITS)
  ) uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .text_byte_in_i   (in_byte),
    .first_of_text_i  (in_first),
    .whole_text_mode_i(in_whole),
    .final_byte_i     (in_final),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (res_kind),
    .line_start_o     (res_line_start),
    .line_count_o     (res_line_count),
    .out_byte_o       (res_byte),
    .line_end_o       (res_line_end),
    .error_code_o     (res_error)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model. Line numbers are kept in 64 bits so that sums of two saturated
  // values never wrap.
  // ---------------------------------------------------------------------------
  parse_state_e    parse_state;
  bit              pending_at;
  logic [7:0]      op_char;
  longint unsigned num_line;
  longint unsigned num_count;
  bit              num_overflow;
  longint unsigned append_floor;
  longint unsigned delete_floor;
  longint unsigned lines_left;
  bit              whole_mode;

  result_t expected_results[$];
  result_t want_r;
  int      fail_count = 0;
  int      sent_beats = 0;

  function automatic void clear_state();
    parse_state  = ST_IDLE;
    pending_at   = 1'b0;
    op_char      = 8'h00;
    num_line     = 0;
    num_count    = 0;
    num_overflow = 1'b0;
    append_floor = 0;
    delete_floor = 0;
    lines_left   = 0;
    whole_mode   = 1'b0;
  endfunction

  function automatic result_t make_result(kind_t k, longint unsigned ls, longint unsigned lc,
                                          logic [7:0] ob, logic le, err_t ec);
    result_t r;
    r.kind       = k;
    r.line_start = ls[OUT_LINE_W-1:0];
    r.line_count = lc[OUT_LINE_W-1:0];
    r.out_byte   = ob;
    r.line_end   = le;
    r.error_code = ec;
    return r;
  endfunction

  // Any error drops the text and sends the parser back to idle.
  function automatic result_t abort_text(err_t code);
    parse_state = ST_IDLE;
    pending_at  = 1'b0;
    return make_result(KIND_ERROR, 0, 0, 8'h00, 1'b0, code);
  endfunction

  function automatic result_t close_text();
    parse_state = ST_IDLE;
    pending_at  = 1'b0;
    return make_result(KIND_END, 0, 0, 8'h00, 1'b0, ERR_NONE);
  endfunction

  // Decimal accumulate with saturation at the line bound.
  function automatic longint unsigned accumulate(longint unsigned v, logic [7:0] c);
    v = v * 10 + longint'(c - CH_ZERO);
    if (v > LINE_MAX) begin
      num_overflow = 1'b1;
      v = LINE_MAX;
    end
    return v;
  endfunction

  // One unescaped character, or the end of the text when at_eof is set.
  function automatic bit parse_char(input bit at_eof, input logic [7:0] c, output result_t r);
    bit digit;
    digit = !at_eof && c >= CH_ZERO && c <= CH_NINE;
    r = '0;
    case (parse_state)
      ST_CMD: begin
        if (at_eof) begin
          r = close_text();
          return 1'b1;
        end
        op_char      = c;
        num_line     = 0;
        num_count    = 0;
        num_overflow = 1'b0;
        parse_state  = ST_NUM1;
        return 1'b0;
      end
      ST_NUM1, ST_SPACES, ST_NUM2, ST_SKIP: begin
        if (at_eof) begin
          r = abort_text(ERR_EARLY_END);
          return 1'b1;
        end
        if (c == CH_NEWLINE) begin
          // The command is complete: validate it and move the floors forward.
          if (num_count == 0 || (op_char != CH_A && op_char != CH_D) || num_overflow ||
              num_line + num_count > LINE_MAX) begin
            r = abort_text(ERR_CORRUPT);
            return 1'b1;
          end
          if (op_char == CH_A) begin
            if (num_line < append_floor) begin
              r = abort_text(ERR_BACK_INS);
              return 1'b1;
            end
            append_floor = num_line + 1;
            lines_left   = num_count;
            parse_state  = ST_LSTART;
            r = make_result(KIND_APPEND, num_line, num_count, 8'h00, 1'b0, ERR_NONE);
            return 1'b1;
          end
          if (num_line < append_floor || num_line < delete_floor) begin
            r = abort_text(ERR_BACK_DEL);
            return 1'b1;
          end
          append_floor = num_line;
          delete_floor = num_line + num_count;
          parse_state  = ST_CMD;
          r = make_result(KIND_DELETE, num_line, num_count, 8'h00, 1'b0, ERR_NONE);
          return 1'b1;
        end
        case (parse_state)
          ST_NUM1: begin
            if (digit) num_line = accumulate(num_line, c);
            else parse_state = (c == CH_SPACE) ? ST_SPACES : ST_SKIP;
          end
          ST_SPACES: begin
            if (digit) begin
              num_count = accumulate(num_count, c);
              parse_state = ST_NUM2;
            end else if (c != CH_SPACE) begin
              parse_state = ST_SKIP;
            end
          end
          ST_NUM2: begin
            if (digit) num_count = accumulate(num_count, c);
            else parse_state = ST_SKIP;
          end
          default: ;
        endcase
        return 1'b0;
      end
      ST_LSTART, ST_LMID: begin
        if (at_eof) begin
          // A last appended line may end without its newline.
          if (whole_mode || (parse_state == ST_LMID && lines_left <= 1)) r = close_text();
          else r = abort_text(ERR_EARLY_END);
          return 1'b1;
        end
        if (c == CH_NEWLINE) begin
          if (whole_mode) begin
            parse_state = ST_LSTART;
          end else begin
            if (lines_left > 0) lines_left--;
            parse_state = (lines_left == 0) ? ST_CMD : ST_LSTART;
          end
        end else begin
          parse_state = ST_LMID;
        end
        r = make_result(KIND_TEXT, 0, 0, c, c == CH_NEWLINE, ERR_NONE);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Model of one accepted input beat; returns 1 when a result beat follows.
  function automatic bit predict_beat(input logic [7:0] b, input logic f, input logic w,
                                      input logic fin, output result_t r);
    bit got;
    got = 1'b0;
    r = '0;
    if (f) begin
      clear_state();
      whole_mode = w;
      if (b != CH_AT) begin
        r = abort_text(ERR_MISSING_AT);
        return 1'b1;
      end
      if (fin) begin
        r = abort_text(ERR_EARLY_END);
        return 1'b1;
      end
      parse_state = w ? ST_LSTART : ST_CMD;
      return 1'b0;
    end
    if (parse_state == ST_IDLE) return 1'b0;
    if (pending_at) begin
      // A second '@' is an escaped one; anything else closes the text and is dropped.
      pending_at = 1'b0;
      got = parse_char(b != CH_AT, b, r);
    end else if (b == CH_AT) begin
      if (fin) got = parse_char(1'b1, b, r);
      else pending_at = 1'b1;
    end else begin
      got = parse_char(1'b0, b, r);
    end
    // A final beat that leaves the text open overrides whatever was produced.
    if (fin && parse_state != ST_IDLE) begin
      r = abort_text(ERR_EARLY_END);
      return 1'b1;
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Beats go out in bursts with random gaps in between; steady_sender
  // suppresses the gaps. All inputs change only with nonblocking assignments
  // right after a rising edge, and handshakes are sampled at the edge itself.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit steady_sender = 1'b0;

  task automatic send_beat(input logic [7:0] b, input logic f, input logic w, input logic fin);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0 && !steady_sender) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_first <= f;
    in_whole <= w;
    in_final <= fin;
    do begin
      @(posedge clk);
    end while (in_stall);
    sent_beats++;
    if (predict_beat(b, f, w, fin, r)) expected_results.push_back(r);
  endtask

  task automatic open_text(input bit whole);
    send_beat(CH_AT, 1'b1, whole, 1'b0);
  endtask

  // Content byte inside an open text: '@' goes out doubled. The mode bit is ignored
  // past the first beat, so it is toggled freely.
  task automatic send_content(input logic [7:0] b);
    if (b == CH_AT) send_beat(b, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
    send_beat(b, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Raw characters for the directed tests, with final_byte optional on the last one.
  task automatic send_chars(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0, 1'b0, fin_last && i == s.len() - 1);
    end
  endtask

  task automatic send_number(input longint unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) send_content(CH_ZERO);
    for (int i = 0; i < digits.len(); i++) send_content(digits[i]);
  endtask

  task automatic send_line(input bit with_newline);
    logic [7:0] b;
    int len;
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_NEWLINE) b = CH_SPACE;
      send_content(b);
    end
    if (with_newline) send_content(CH_NEWLINE);
  endtask

  // Closing '@' in its various forms: with final_byte, followed by a dropped beat,
  // or left pending so that the next opening beat abandons it.
  task automatic close_text_seq();
    logic [7:0] tail;
    case ($urandom_range(0, 3))
      0: send_beat(CH_AT, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
      1, 2: begin
        send_beat(CH_AT, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
        tail = 8'($urandom_range(0, 255));
        if (tail == CH_AT) tail = CH_SPACE;
        send_beat(tail, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      default: send_beat(CH_AT, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
    endcase
  endtask

  // A delta script whose commands move forward, with an occasional damaged command.
  task automatic gen_delta_text();
    longint unsigned af, df, l, n;
    logic [7:0] op;
    fault_e fault;
    bit is_del;
    int ncmd;
    af = 0;
    df = 0;
    open_text(1'b0);
    ncmd = $urandom_range(1, 6);
    for (int c = 0; c < ncmd; c++) begin
      is_del = ($urandom_range(0, 2) == 0);
      if (is_del) begin
        l  = ((af > df) ? af : df) + longint'($urandom_range(0, 5));
        n  = $urandom_range(1, 4);
        op = CH_D;
      end else begin
        l  = af + longint'($urandom_range(0, 5));
        n  = $urandom_range(1, 3);
        op = CH_A;
      end
      fault = ($urandom_range(0, 11) == 0) ? fault_e'($urandom_range(1, 6)) : FLT_NONE;
      case (fault)
        FLT_OPCODE:     op = 8'($urandom_range(0, 255));
        FLT_ZERO_COUNT: n = 0;
        FLT_BEHIND:     l = $urandom_range(0, 3);
        FLT_NEAR_MAX:   l = LINE_MAX - longint'($urandom_range(0, 3));
        FLT_HUGE:       l = 64'd99999999;
        default: ;
      endcase
      send_content(op);
      // Now and then the line number is left out and reads as zero.
      if ($urandom_range(0, 15) != 0) send_number(l);
      if (fault == FLT_CUT) begin
        close_text_seq();
        return;
      end
      repeat ($urandom_range(1, 3)) send_content(CH_SPACE);
      send_number(n);
      if ($urandom_range(0, 9) == 0) begin
        send_content(CH_SPACE);
        send_content(8'($urandom_range(8'h61, 8'h7a)));
      end
      send_content(CH_NEWLINE);
      if (is_del) begin
        af = l;
        df = l + n;
      end else begin
        af = l + 1;
        for (int k = 0; k < n; k++) begin
          send_line(!(c == ncmd - 1 && k == n - 1 && $urandom_range(0, 2) == 0));
        end
      end
    end
    close_text_seq();
  endtask

  task automatic gen_whole_text();
    logic [7:0] b;
    int len;
    open_text(1'b1);
    len = $urandom_range(0, 40);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 6) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255));
      send_content(b);
    end
    close_text_seq();
  endtask

  // Beats with every flag random: bad openings, stray final marks, idle bytes.
  task automatic gen_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      b = ($urandom_range(0, 3) == 0) ? CH_AT : 8'($urandom_range(0, 255));
      send_beat(b, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                $urandom_range(0, 5) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. The stall pattern changes mode every so often: no stall, light or
  // heavy random stall, or a periodic duty cycle. A long hold can be requested by
  // bumping hold_seq; the hold is counted here, in the receiver's own process.
  // ---------------------------------------------------------------------------
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_period = 2;
  int stall_duty = 1;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode   = $urandom_range(0, 3);
      mode_left    = $urandom_range(32, 256);
      stall_period = $urandom_range(2, 9);
      stall_duty   = $urandom_range(1, stall_period - 1);
    end else begin
      mode_left--;
    end
    stall_phase = (stall_phase + 1) % stall_period;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (stall_phase < stall_duty);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result beat must match the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing expected, actual kind %0d error %0d byte %0d",
                 $time, res_kind, res_error, res_byte);
      end else begin
        want_r = expected_results.pop_front();
        compare_field("kind", want_r.kind, res_kind);
        compare_field("line_start", want_r.line_start, res_line_start);
        compare_field("line_count", want_r.line_count, res_line_count);
        compare_field("out_byte", want_r.out_byte, res_byte);
        compare_field("line_end", want_r.line_end, res_line_end);
        compare_field("error_code", want_r.error_code, res_error);
      end
    end
  end

  // Overall watchdog.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The opening beat must be '@', and must not also be the final beat.
  task automatic test_open_checks();
    send_beat("x", 1'b1, 1'b0, 1'b0);
    send_beat(CH_AT, 1'b1, 1'b1, 1'b1);
  endtask

  // Whole-text mode passes every byte on, including escaped '@', 0x00 and 0xff.
  task automatic test_whole_text();
    open_text(1'b1);
    send_chars("a@@\n\n", 1'b0);
    send_beat(8'hff, 1'b0, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1, 1'b0);
    send_chars("@ ", 1'b0);
  endtask

  // Well-formed commands, odd spacing, leading zeros, trailing junk, missing digits.
  task automatic test_delta_commands();
    open_text(1'b0);
    send_chars("d1 2\na3  02 junk\nxy\n\nd5 1\n@z", 1'b0);
    open_text(1'b0);
    send_chars("a 3\np\nq\nr\n@", 1'b1);
    // Last appended line without its newline still closes cleanly.
    open_text(1'b0);
    send_chars("a0 1\nlast@", 1'b1);
    // Junk right after the opcode's number leaves the count at zero.
    open_text(1'b0);
    send_chars("a2x7 1\n", 1'b0);
  endtask

  // Line bound, saturation, zero count and illegal opcodes.
  task automatic test_number_limits();
    open_text(1'b0);
    send_chars("a16777214 1\nq\n@ ", 1'b0);
    open_text(1'b0);
    send_chars("a16777215 1\n", 1'b0);
    open_text(1'b0);
    send_chars("d16777216 1\n", 1'b0);
    open_text(1'b0);
    send_chars("a1 0\n", 1'b0);
    open_text(1'b0);
    send_chars("x1 1\n", 1'b0);
    open_text(1'b0);
    send_chars("@@1 1\n", 1'b0);
  endtask

  // Forward-ordering checks for inserts and deletes.
  task automatic test_ordering();
    open_text(1'b0);
    send_chars("a5 1\nz\na4 1\n", 1'b0);
    open_text(1'b0);
    send_chars("d5 2\nd6 1\n", 1'b0);
    open_text(1'b0);
    send_chars("a5 1\nz\nd5 1\n", 1'b0);
    open_text(1'b0);
    send_chars("d5 2\na5 1\nk\na7 1\nk\n@ ", 1'b0);
  endtask

  // Text ending inside a command or inside appended lines, and a final beat
  // that arrives before the closing '@'.
  task automatic test_early_end();
    open_text(1'b0);
    send_chars("a1 2\nx\n@ ", 1'b0);
    open_text(1'b0);
    send_chars("a1 2\nx@ ", 1'b0);
    open_text(1'b0);
    send_chars("d1@ ", 1'b0);
    open_text(1'b0);
    send_chars("d1 1\n", 1'b1);
    open_text(1'b1);
    send_chars("abc", 1'b1);
  endtask

  // A new opening beat abandons a text silently, also right after a lone '@';
  // bytes after the end are ignored until the next opening beat.
  task automatic test_abandon_and_idle();
    open_text(1'b0);
    send_chars("a1 1\nab", 1'b0);
    open_text(1'b1);
    send_chars("hi@ ", 1'b0);
    send_chars("zz@@\n", 1'b0);
    send_beat(CH_AT, 1'b0, 1'b0, 1'b1);
    open_text(1'b0);
    send_chars("@", 1'b0);
    open_text(1'b1);
    send_chars("@ ", 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats back to back, so the block fills and has to stall its input.
  task automatic test_backpressure();
    steady_sender = 1'b1;
    hold_seq++;
    open_text(1'b1);
    repeat (80) begin
      send_content(($urandom_range(0, 7) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255)));
    end
    send_beat(CH_AT, 1'b0, 1'b0, 1'b1);
    steady_sender = 1'b0;
  endtask

  task automatic test_random_texts();
    int start;
    int pick;
    start = sent_beats;
    while (sent_beats - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) gen_delta_text();
      else if (pick < 9) gen_whole_text();
      else gen_noise();
    end
  endtask

  initial begin
    int waited;
    clear_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_open_checks();
    test_whole_text();
    test_delta_commands();
    test_number_limits();
    test_ordering();
    test_early_end();
    test_abandon_and_idle();
    test_backpressure();
    test_random_texts();
    in_valid <= 1'b0;

    // Let every predicted result arrive, then a few more cycles for strays.
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected result beats never arrived, oldest kind %0d",
               $time, expected_results.size(), expected_results[0].kind);
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
